// ===== rtl/bmm_pkg.sv =====
// bmm_pkg: shared constants for the box measurement merge table
// result status codes and fixed field widths, no dependencies
package bmm_pkg;

    localparam int IDX_W  = 5;
    localparam int CNT_W  = 16;
    localparam int STAT_W = 3;
    localparam int AXES   = 3;
    localparam int FIELDS = 6;

    localparam logic [STAT_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RD_ENTRY = 3'd3;
    localparam logic [STAT_W-1:0] ST_RD_EMPTY = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

endpackage

// ===== rtl/box_measurement_merge_table.sv =====
// box_measurement_merge_table: first-match table of box measurements with running means
// depends on bmm_pkg, bmm_table and bmm_div
//
// An add item scans the filled entries in order, reading each one from memory and squaring
// the six axis differences one at a time on a single shared multiplier.
// A merge is then bounded by the serial divider that forms each running mean one quotient
// bit per cycle; with no match the item is appended, or dropped when the table is full.
// A readout emits the filled entries in order, one item at a time. The input is not ready
// until the item's last result has been handed to the output register.
module box_measurement_merge_table
    import bmm_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 16,
    localparam int IDW = ((FIELDS * COORD_BITS + 7) / 8) * 8,
    localparam int ODW = ((IDX_W + FIELDS * COORD_BITS + CNT_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // size_x, size_y, size_z, center_x, center_y, center_z
    input  logic [IDW-1:0]     s_axis_tdata,
    // req_type
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // entry_index, out_size_x/y/z, out_center_x/y/z, capture_count
    output logic [ODW-1:0]     m_axis_tdata,
    // status
    output logic [STAT_W-1:0]  m_axis_tuser,
    output logic               m_axis_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CB  = COORD_BITS;
    localparam int VW  = FIELDS * CB;
    localparam int EW  = VW + CNT_W;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW  = $clog2(TABLE_DEPTH + 1);
    localparam int MB  = (CB + 1 > 17) ? CB + 1 : 17;
    localparam int PW  = 17 + MB;
    localparam int NW  = PW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_WAIT, S_RD_OUT, S_SC_WAIT, S_SC_LOAD, S_SC_MUL, S_SC_ACC,
        S_MG_MUL, S_MG_ADD, S_MG_DIV, S_MG_WR, S_EMIT
    } t_state;

    t_state              r_state;
    logic [31:0]         r_radius;
    logic [FW-1:0]       r_fill;
    logic [AW-1:0]       r_idx;
    logic                r_req;
    logic [VW-1:0]       r_meas;
    logic [EW-1:0]       r_ent;
    logic [2:0]          r_k;
    logic signed [PW-1:0] r_prod;
    logic [33:0]         r_acc;
    logic                r_ovf;
    logic                r_fail;
    logic                r_neg;
    logic                r_div_start;
    logic [NW-1:0]       r_dividend;
    logic                r_we;
    logic [AW-1:0]       r_waddr;
    logic [EW-1:0]       r_wdata;
    logic [STAT_W-1:0]   r_st_status;
    logic [IDX_W-1:0]    r_st_idx;
    logic [VW-1:0]       r_st_vals;
    logic [CNT_W-1:0]    r_st_cnt;
    logic                r_st_last;
    logic                r_ov;
    logic [STAT_W-1:0]   r_o_status;
    logic [IDX_W-1:0]    r_o_idx;
    logic [VW-1:0]       r_o_vals;
    logic [CNT_W-1:0]    r_o_cnt;
    logic                r_o_last;

    logic [EW-1:0]       rd_data;
    logic                div_done;
    logic [NW-1:0]       div_quo;
    logic [CB-1:0]       m_fld;
    logic [CB-1:0]       e_fld;
    logic                is_ctr;
    logic signed [CB+1:0] m_x;
    logic signed [CB+1:0] e_x;
    logic signed [CB+1:0] diff;
    logic [CB+1:0]       mag_full;
    logic [32:0]         mag33;
    logic                over;
    logic signed [16:0]  mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [33:0]         sum3;
    logic                grp_fail;
    logic signed [NW-1:0] num;
    logic [NW-1:0]       q_s;
    logic [CNT_W-1:0]    e_cnt;
    logic [CNT_W-1:0]    c_new;
    logic [AW-1:0]       last_idx;
    logic                full;
    logic                cfg_wr;

    bmm_table #(.DEPTH(TABLE_DEPTH), .W(EW), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    bmm_div #(.NW(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (17'(e_cnt) + 17'd1),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign m_fld    = r_meas[r_k*CB +: CB];
    assign e_fld    = r_ent[r_k*CB +: CB];
    assign e_cnt    = r_ent[VW +: CNT_W];
    assign is_ctr   = (r_k >= 3'(AXES));
    assign m_x      = is_ctr ? (CB+2)'(signed'(m_fld)) : signed'((CB+2)'(m_fld));
    assign e_x      = is_ctr ? (CB+2)'(signed'(e_fld)) : signed'((CB+2)'(e_fld));
    assign diff     = m_x - e_x;
    assign mag_full = diff[CB+1] ? unsigned'(-diff) : unsigned'(diff);
    assign mag33    = 33'(mag_full[CB-1:0]);
    assign over     = (mag33 > 33'h0FFFF);

    always_comb begin
        if (r_state == S_SC_MUL) begin
            mul_a = signed'(17'(mag33[15:0]));
            mul_b = signed'(MB'(mag33[15:0]));
        end else begin
            mul_a = signed'(17'(e_cnt));
            mul_b = is_ctr ? MB'(signed'(e_fld)) : signed'(MB'(e_fld));
        end
    end

    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign sum3     = r_acc + 34'(r_prod[31:0]);
    assign grp_fail = r_fail || r_ovf || (sum3 >= 34'(r_radius));
    assign num      = NW'(r_prod) + (is_ctr ? NW'(signed'(m_fld)) : signed'(NW'(m_fld)));
    assign q_s      = r_neg ? (~div_quo + 1'b1) : div_quo;
    assign c_new    = (e_cnt < CNT_MAX) ? e_cnt + 1'b1 : e_cnt;
    assign last_idx = AW'(r_fill - 1'b1);
    assign full     = (r_fill == FW'(TABLE_DEPTH));
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= 32'd42025;
            r_fill      <= '0;
            r_ov        <= 1'b0;
            r_we        <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_we        <= 1'b0;
            r_div_start <= 1'b0;
            if (cfg_wr) begin
                r_radius <= pwdata;
            end
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req  <= s_axis_tuser;
                        r_meas <= s_axis_tdata[VW-1:0];
                        r_idx  <= '0;
                        if (s_axis_tuser) begin
                            if (r_fill == '0) begin
                                r_st_status <= ST_RD_EMPTY;
                                r_st_idx    <= '0;
                                r_st_vals   <= '0;
                                r_st_cnt    <= '0;
                                r_st_last   <= 1'b1;
                                r_state     <= S_EMIT;
                            end else begin
                                r_state <= S_RD_WAIT;
                            end
                        end else if (r_fill == '0) begin
                            r_we        <= 1'b1;
                            r_waddr     <= '0;
                            r_wdata     <= {CNT_W'(1), s_axis_tdata[VW-1:0]};
                            r_fill      <= FW'(1);
                            r_st_status <= ST_APPENDED;
                            r_st_idx    <= '0;
                            r_st_vals   <= s_axis_tdata[VW-1:0];
                            r_st_cnt    <= CNT_W'(1);
                            r_st_last   <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_SC_WAIT;
                        end
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    r_st_status <= ST_RD_ENTRY;
                    r_st_idx    <= IDX_W'(r_idx);
                    r_st_vals   <= rd_data[VW-1:0];
                    r_st_cnt    <= rd_data[VW +: CNT_W];
                    r_st_last   <= (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        r_fill <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_SC_WAIT: begin
                    r_state <= S_SC_LOAD;
                end
                S_SC_LOAD: begin
                    r_ent   <= rd_data;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_ovf   <= 1'b0;
                    r_fail  <= 1'b0;
                    r_state <= S_SC_MUL;
                end
                S_SC_MUL: begin
                    r_prod  <= prod;
                    r_ovf   <= r_ovf | over;
                    r_state <= S_SC_ACC;
                end
                S_SC_ACC: begin
                    r_k     <= r_k + 1'b1;
                    r_state <= S_SC_MUL;
                    if (r_k == 3'(AXES - 1)) begin
                        r_fail <= grp_fail;
                        r_acc  <= '0;
                        r_ovf  <= 1'b0;
                    end else if (r_k == 3'(FIELDS - 1)) begin
                        r_k <= '0;
                        if (!grp_fail) begin
                            r_state <= S_MG_MUL;
                        end else if (r_idx != last_idx) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SC_WAIT;
                        end else if (!full) begin
                            r_we        <= 1'b1;
                            r_waddr     <= AW'(r_fill);
                            r_wdata     <= {CNT_W'(1), r_meas};
                            r_fill      <= r_fill + 1'b1;
                            r_st_status <= ST_APPENDED;
                            r_st_idx    <= IDX_W'(r_fill);
                            r_st_vals   <= r_meas;
                            r_st_cnt    <= CNT_W'(1);
                            r_st_last   <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_st_status <= ST_DROPPED;
                            r_st_idx    <= '0;
                            r_st_vals   <= r_meas;
                            r_st_cnt    <= '0;
                            r_st_last   <= 1'b1;
                            r_state     <= S_EMIT;
                        end
                    end else begin
                        r_acc <= sum3;
                    end
                end
                S_MG_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_MG_ADD;
                end
                S_MG_ADD: begin
                    r_neg       <= num[NW-1];
                    r_dividend  <= num[NW-1] ? unsigned'(-num) : unsigned'(num);
                    r_div_start <= 1'b1;
                    r_state     <= S_MG_DIV;
                end
                S_MG_DIV: begin
                    if (div_done) begin
                        r_ent[r_k*CB +: CB] <= q_s[CB-1:0];
                        if (r_k == 3'(FIELDS - 1)) begin
                            r_state <= S_MG_WR;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MG_MUL;
                        end
                    end
                end
                S_MG_WR: begin
                    r_we        <= 1'b1;
                    r_waddr     <= r_idx;
                    r_wdata     <= {c_new, r_ent[VW-1:0]};
                    r_st_status <= ST_MERGED;
                    r_st_idx    <= IDX_W'(r_idx);
                    r_st_vals   <= r_ent[VW-1:0];
                    r_st_cnt    <= c_new;
                    r_st_last   <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_st_status;
                        r_o_idx    <= r_st_idx;
                        r_o_vals   <= r_st_vals;
                        r_o_cnt    <= r_st_cnt;
                        r_o_last   <= r_st_last;
                        if (r_st_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD_WAIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = ODW'({r_o_cnt, r_o_vals, r_o_idx});
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;
    assign prdata        = paddr[2] ? 32'd0 : r_radius;
    assign pready        = 1'b1;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_DEPTH))
        else $error("fill level beyond table depth");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_RD_EMPTY) |-> m_axis_tlast)
        else $error("empty readout item without last");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MG_DIV))
        else $error("divider finished outside merge");

    a_req_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_OUT) |-> r_req)
        else $error("readout step on an add item");

endmodule

// ===== rtl/bmm_table.sv =====
// bmm_table: entry memory of the merge table, one write and one read port
// read data registered; uses no package items beyond the import
module bmm_table
    import bmm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int W     = 112,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmm_div.sv =====
// bmm_div: restoring serial divider, one quotient bit per cycle
// unsigned dividend of NW bits by a 17-bit divisor; imports bmm_pkg but uses none of its items
module bmm_div
    import bmm_pkg::*;
#(
    parameter int NW = 51
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [16:0]   i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [17:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [16:0]   r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [17:0]   shifted;

    assign shifted = {r_rem[16:0], r_quo[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (shifted >= {1'b0, r_dvs}) begin
                    r_rem <= shifted - {1'b0, r_dvs};
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
